// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the design files.
// Each macro expects signals named clk and arst_n in the enclosing scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Clocked implication, antecedent holds in the same cycle as the consequent.
`define ASSERT_IMPL(label, ante, cons, msg) \
	`ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

// ===== design/u8d_pkg.sv =====
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types, error codes and helper functions for the UTF-8 decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_INVALID   = 3'd1;
	localparam logic [2:0] ERR_TRUNCATED = 3'd2;
	localparam logic [2:0] ERR_OVERLONG  = 3'd3;
	localparam logic [2:0] ERR_BAD_LEAD  = 3'd4;

	localparam logic [20:0] SURR_LO   = 21'h00d800;
	localparam logic [20:0] SURR_HI   = 21'h00dfff;
	localparam logic [20:0] CP_LIMIT  = 21'h110000;

	// Stage 1 beat: classified window.
	typedef struct packed {
		logic [2:0] len;
		logic       early;
		logic [2:0] early_err;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] b3;
	} cls_beat_t;

	// Stage 2 beat: assembled code point.
	typedef struct packed {
		logic [2:0]  len;
		logic        early;
		logic [2:0]  early_err;
		logic [20:0] cp;
	} asm_beat_t;

	// Sequence length implied by the lead byte; zero for an illegal lead.
	function automatic logic [2:0] lead_length(input logic [7:0] b);
		logic [2:0] l;
		l = 3'd0;
		if (b[7] == 1'b0) begin
			l = 3'd1;
		end else if (b[7:5] == 3'b110) begin
			l = 3'd2;
		end else if (b[7:4] == 4'b1110) begin
			l = 3'd3;
		end else if (b[7:3] == 5'b11110) begin
			l = 3'd4;
		end
		return l;
	endfunction

	function automatic logic is_cont(input logic [7:0] b);
		return b[7:6] == 2'b10;
	endfunction

	// Smallest code point that may legally use a sequence of this length.
	function automatic logic [20:0] min_for_len(input logic [2:0] l);
		logic [20:0] m;
		case (l)
			3'd2:    m = 21'h000080;
			3'd3:    m = 21'h000800;
			3'd4:    m = 21'h010000;
			default: m = 21'h000000;
		endcase
		return m;
	endfunction

endpackage

// ===== design/u8d_classify.sv =====
// ----------------------------------------------------------------------------
// u8d_classify
// First stage: sequence length, truncation, continuation and lead checks.
// ----------------------------------------------------------------------------
module u8d_classify (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [7:0]          lead_byte,
	input  logic [7:0]          second_byte,
	input  logic [7:0]          third_byte,
	input  logic [7:0]          fourth_byte,
	input  logic [2:0]          bytes_left,
	output logic                valid_s1,
	output u8d_pkg::cls_beat_t  beat_s1
);
	import u8d_pkg::*;

	logic [2:0] len;
	logic [2:0] left_sat;
	logic       trunc;
	logic       bad_cont;
	cls_beat_t  beat_d;

	always_comb begin
		len      = lead_length(lead_byte);
		left_sat = (bytes_left > 3'd4) ? 3'd4 : bytes_left;
		trunc    = len > left_sat;
		// Only the bytes the sequence needs are checked.
		bad_cont = (len >= 3'd2 && !is_cont(second_byte)) ||
			(len >= 3'd3 && !is_cont(third_byte)) ||
			(len == 3'd4 && !is_cont(fourth_byte));

		beat_d.len       = len;
		beat_d.b0        = lead_byte;
		beat_d.b1        = second_byte;
		beat_d.b2        = third_byte;
		beat_d.b3        = fourth_byte;
		beat_d.early     = trunc || bad_cont || (len == 3'd0);
		if (trunc) begin
			beat_d.early_err = ERR_TRUNCATED;
		end else if (bad_cont) begin
			beat_d.early_err = ERR_INVALID;
		end else if (len == 3'd0) begin
			beat_d.early_err = ERR_BAD_LEAD;
		end else begin
			beat_d.early_err = ERR_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		beat_s1 <= beat_d;
	end

endmodule

// ===== design/u8d_assemble.sv =====
// ----------------------------------------------------------------------------
// u8d_assemble
// Second stage: builds the code point from the payload bits of the window.
// ----------------------------------------------------------------------------
module u8d_assemble (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s1,
	input  u8d_pkg::cls_beat_t  beat_s1,
	output logic                valid_s2,
	output u8d_pkg::asm_beat_t  beat_s2
);
	import u8d_pkg::*;

	logic [20:0] cp;
	asm_beat_t   beat_d;

	always_comb begin
		case (beat_s1.len)
			3'd1:    cp = {13'd0, beat_s1.b0};
			3'd2:    cp = {10'd0, beat_s1.b0[4:0], beat_s1.b1[5:0]};
			3'd3:    cp = {5'd0, beat_s1.b0[3:0], beat_s1.b1[5:0], beat_s1.b2[5:0]};
			3'd4:    cp = {beat_s1.b0[2:0], beat_s1.b1[5:0], beat_s1.b2[5:0],
				beat_s1.b3[5:0]};
			default: cp = 21'd0;
		endcase
		// Early errors report a zero code point and a zero length.
		beat_d.early     = beat_s1.early;
		beat_d.early_err = beat_s1.early_err;
		beat_d.len       = beat_s1.early ? 3'd0 : beat_s1.len;
		beat_d.cp        = beat_s1.early ? 21'd0 : cp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		beat_s2 <= beat_d;
	end

endmodule

// ===== design/u8d_check.sv =====
// ----------------------------------------------------------------------------
// u8d_check
// Third stage: overlong, surrogate and range checks, then the result register.
// ----------------------------------------------------------------------------
module u8d_check (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s2,
	input  u8d_pkg::asm_beat_t  beat_s2,
	output logic                valid_s3,
	output logic [20:0]         cp_s3,
	output logic [2:0]          len_s3,
	output logic [2:0]          err_s3
);
	import u8d_pkg::*;

	logic       overlong;
	logic       bad_value;
	logic [2:0] err;

	always_comb begin
		overlong  = beat_s2.cp < min_for_len(beat_s2.len);
		bad_value = (beat_s2.cp inside {[SURR_LO:SURR_HI]}) || (beat_s2.cp >= CP_LIMIT);
		// A bad value outranks an overlong form.
		if (beat_s2.early) begin
			err = beat_s2.early_err;
		end else if (bad_value) begin
			err = ERR_INVALID;
		end else if (overlong) begin
			err = ERR_OVERLONG;
		end else begin
			err = ERR_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		cp_s3  <= beat_s2.cp;
		len_s3 <= beat_s2.len;
		err_s3 <= err;
	end

endmodule

// ===== design/utf8_validating_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_validating_decoder
// Pipeline: a sequence accepted at a clock edge is registered in stage 1,
// then in stage 2, then in the stage 3 result registers that drive the ports,
// where it is marked by done for exactly one cycle.
// Throughput: one sequence per cycle; busy is never raised, since none of
// the three register stages ever stalls.
// Reset: arst_n clears the stage valid bits at once; nothing else is kept.
// ----------------------------------------------------------------------------
module utf8_validating_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  lead_byte,
	input  logic [7:0]  second_byte,
	input  logic [7:0]  third_byte,
	input  logic [7:0]  fourth_byte,
	input  logic [2:0]  bytes_left,
	output logic        done,
	output logic [20:0] code_point,
	output logic [2:0]  seq_length,
	output logic [2:0]  error_code
);
	import u8d_pkg::*;

	// The decode carries no state from one beat to the next, so the pipeline
	// takes a new beat in every cycle and never needs to hold the sender off.
	logic      valid_s1;
	logic      valid_s2;
	cls_beat_t beat_s1;
	asm_beat_t beat_s2;

	assign busy = 1'b0;

	// Stage 1 works out the length from the lead byte and resolves the early
	// errors in their order of precedence: truncation, then a continuation
	// byte of the wrong form, then an illegal lead.
	u8d_classify u_classify (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (start),
		.lead_byte   (lead_byte),
		.second_byte (second_byte),
		.third_byte  (third_byte),
		.fourth_byte (fourth_byte),
		.bytes_left  (bytes_left),
		.valid_s1    (valid_s1),
		.beat_s1     (beat_s1)
	);

	// Stage 2 strips the marker bits and concatenates the payload bits. An
	// early error forces the code point and the length to zero here.
	u8d_assemble u_assemble (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1),
		.valid_s2 (valid_s2),
		.beat_s2  (beat_s2)
	);

	// Stage 3 compares the code point against the minimum for its length and
	// against the surrogate range and the top of the code space; its outputs
	// are the result registers that drive the ports.
	u8d_check u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.beat_s2  (beat_s2),
		.valid_s3 (done),
		.cp_s3    (code_point),
		.len_s3   (seq_length),
		.err_s3   (error_code)
	);

	`include "assert_macros.svh"

	// Every result comes from a beat accepted by start that has passed through the three register stages.
	`ASSERT_IMPL(a_done_latency, done, $past(start, 3), "result with no beat three cycles back")
	// A result reported with no length must carry a zero code point.
	`ASSERT_IMPL(a_zero_len_zero_cp, done && (seq_length == 3'd0),
		code_point == 21'd0, "nonzero code point with zero length")
	// A clean result always consumed at least one byte.
	`ASSERT_IMPL(a_clean_has_len, done && (error_code == ERR_NONE),
		(seq_length != 3'd0) && (seq_length <= 3'd4), "clean result with bad length")

endmodule
